// File: hdl/i2c_eeprom_byte_master_top_defines.svh
// Assertion macros used by the I2C EEPROM byte master sequencer
`ifndef I2C_EEPROM_BYTE_MASTER_TOP_DEFINES_SVH
`define I2C_EEPROM_BYTE_MASTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Concurrent property check, sampled on clk_i, disabled in reset
`define I2CEBM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("i2cebm assertion failed");
// Next-cycle implication check
`define I2CEBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cebm assertion failed");
`else
`define I2CEBM_ASSERT(label, prop)
`define I2CEBM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/i2cebm_pkg.sv
// Shared types and constants of the I2C EEPROM byte master
package i2cebm_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS = 2'd0,
    REG_PHASE_TICKS    = 2'd1
  } cfg_reg_e;

  // Request kinds carried by each tick
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  localparam logic [6:0]  DEV_ADDR_RESET    = 7'd80;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd1;

  // One input tick
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mem_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // One result per tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_byte;
  } res_t;

endpackage

// File: hdl/i2cebm_if.sv
// Handshake interfaces for tick input, result output and configuration writes
interface i2cebm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] mem_addr;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, kind, mem_addr, write_data, sda_in, input ready);
  modport sink   (input valid, kind, mem_addr, write_data, sda_in, output ready);
endinterface

interface i2cebm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic       ack_error;
  logic [7:0] read_byte;

  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, ack_error,
                  read_byte, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res, ack_error,
                  read_byte, output ready);
endinterface

interface i2cebm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/i2cebm_seq.sv
// Bus sequencer: state registers, configuration registers and per-tick result logic
`include "i2c_eeprom_byte_master_top_defines.svh"

module i2cebm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  i2cebm_pkg::item_t   item_i,
  i2cebm_cfg_if.sink          cfg_i,
  output i2cebm_pkg::res_t    res_o
);
  import i2cebm_pkg::*;

  // Bus phase codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SA   = 4'd1;
  localparam logic [3:0] ST_SB   = 4'd2;
  localparam logic [3:0] ST_SC   = 4'd3;
  localparam logic [3:0] ST_RS   = 4'd4;
  localparam logic [3:0] ST_TXL  = 4'd5;
  localparam logic [3:0] ST_TXH  = 4'd6;
  localparam logic [3:0] ST_AKL  = 4'd7;
  localparam logic [3:0] ST_AKH  = 4'd8;
  localparam logic [3:0] ST_RXL  = 4'd9;
  localparam logic [3:0] ST_RXH  = 4'd10;
  localparam logic [3:0] ST_NKL  = 4'd11;
  localparam logic [3:0] ST_NKH  = 4'd12;
  localparam logic [3:0] ST_PA   = 4'd13;
  localparam logic [3:0] ST_PB   = 4'd14;
  localparam logic [3:0] ST_PC   = 4'd15;

  localparam logic [1:0] STG_DEV  = 2'd0;
  localparam logic [1:0] STG_ADDR = 2'd1;
  localparam logic [1:0] STG_DATA = 2'd2;

  logic [6:0]  dev_addr_q;
  logic [15:0] phase_ticks_q;

  logic [3:0]  state_q, state_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] phase_q, phase_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic        rd_q, rd_d;
  logic [7:0]  last_q, last_d;
  logic [1:0]  stage_q, stage_d;
  logic        nack_q, nack_d;

  logic        start;
  logic [3:0]  cur;
  logic [3:0]  bit_e;
  logic [3:0]  bit_inc;
  logic [15:0] phase_e;
  logic [1:0]  stage_e;
  logic        nack_e;
  logic [15:0] len;
  logic        phase_end;
  logic        tx_bit_n;
  res_t        res;

  // Configuration writes, always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEV_ADDR_RESET;
      phase_ticks_q <= PHASE_TICKS_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEVICE_ADDRESS: dev_addr_q    <= cfg_i.data[6:0];
        REG_PHASE_TICKS:    phase_ticks_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A request in idle starts the transaction on this same tick
  assign start   = (state_q == ST_IDLE) &&
                   (item_i.kind == KIND_WRITE || item_i.kind == KIND_READ);
  assign cur     = start ? ST_SA : state_q;
  assign bit_e   = start ? 4'd0 : bit_q;
  assign phase_e = start ? 16'd0 : phase_q;
  assign stage_e = start ? STG_DEV : stage_q;
  assign nack_e  = start ? 1'b0 : nack_q;
  assign bit_inc = bit_e + 4'd1;
  assign len     = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
  assign phase_end = (({1'b0, phase_e} + 17'd1) >= {1'b0, len});
  assign tx_bit_n  = ~shift_q[7];

  // Line levels, busy/done/ack results and phase transitions
  always_comb begin
    state_d = cur;
    bit_d   = bit_e;
    shift_d = shift_q;
    phase_d = phase_e;
    addr_d  = start ? item_i.mem_addr : addr_q;
    data_d  = start ? item_i.write_data : data_q;
    rd_d    = start ? (item_i.kind == KIND_READ) : rd_q;
    last_d  = last_q;
    stage_d = stage_e;
    nack_d  = nack_e;
    res     = '0;
    res.scl_level = 1'b1;

    if (cur != ST_IDLE) begin
      res.busy_res = 1'b1;
      unique case (cur)
        ST_SA:  begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0;     end
        ST_SB:  begin res.scl_level = 1'b1; res.sda_pull_low = 1'b1;     end
        ST_SC:  begin res.scl_level = 1'b0; res.sda_pull_low = 1'b1;     end
        ST_TXL: begin res.scl_level = 1'b0; res.sda_pull_low = tx_bit_n; end
        ST_TXH: begin res.scl_level = 1'b1; res.sda_pull_low = tx_bit_n; end
        ST_AKH, ST_RXH, ST_NKH: begin
          res.scl_level = 1'b1; res.sda_pull_low = 1'b0;
        end
        ST_PA:  begin res.scl_level = 1'b0; res.sda_pull_low = 1'b1;     end
        ST_PB:  begin res.scl_level = 1'b1; res.sda_pull_low = 1'b1;     end
        ST_PC:  begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0;     end
        default: begin res.scl_level = 1'b0; res.sda_pull_low = 1'b0;    end
      endcase

      if (phase_end) begin
        phase_d = 16'd0;
        unique case (cur)
          ST_SA: state_d = ST_SB;
          ST_SB: state_d = ST_SC;
          ST_SC: begin
            shift_d = {dev_addr_q, (stage_e == STG_DATA)};
            bit_d   = 4'd0;
            state_d = ST_TXL;
          end
          ST_RS:  state_d = ST_SA;
          ST_TXL: state_d = ST_TXH;
          ST_TXH: begin
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_inc;
            state_d = (bit_inc >= 4'd8) ? ST_AKL : ST_TXL;
          end
          ST_AKL: state_d = ST_AKH;
          ST_AKH: begin
            if (item_i.sda_in) begin
              nack_d  = 1'b1;
              state_d = ST_PA;
            end else if (stage_e == STG_DEV) begin
              stage_d = STG_ADDR;
              shift_d = addr_d;
              bit_d   = 4'd0;
              state_d = ST_TXL;
            end else if (stage_e == STG_ADDR) begin
              stage_d = STG_DATA;
              if (rd_d) begin
                state_d = ST_RS;
              end else begin
                shift_d = data_d;
                bit_d   = 4'd0;
                state_d = ST_TXL;
              end
            end else if (rd_d) begin
              shift_d = 8'd0;
              bit_d   = 4'd0;
              state_d = ST_RXL;
            end else begin
              state_d = ST_PA;
            end
          end
          ST_RXL: state_d = ST_RXH;
          ST_RXH: begin
            shift_d = {shift_q[6:0], item_i.sda_in};
            bit_d   = bit_inc;
            if (bit_inc >= 4'd8) begin
              last_d  = {shift_q[6:0], item_i.sda_in};
              state_d = ST_NKL;
            end else begin
              state_d = ST_RXL;
            end
          end
          ST_NKL: state_d = ST_NKH;
          ST_NKH: state_d = ST_PA;
          ST_PA:  state_d = ST_PB;
          ST_PB:  state_d = ST_PC;
          ST_PC: begin
            state_d       = ST_IDLE;
            res.done_res  = 1'b1;
            res.ack_error = nack_e;
          end
          default: state_d = ST_IDLE;
        endcase
      end else begin
        phase_d = phase_e + 16'd1;
      end
    end
    res.read_byte = last_d;
  end

  assign res_o = res;

  // State advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      phase_q <= 16'd0;
      addr_q  <= 8'd0;
      data_q  <= 8'd0;
      rd_q    <= 1'b0;
      last_q  <= 8'd0;
      stage_q <= STG_DEV;
      nack_q  <= 1'b0;
    end else if (accept_i) begin
      state_q <= state_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      phase_q <= phase_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
      rd_q    <= rd_d;
      last_q  <= last_d;
      stage_q <= stage_d;
      nack_q  <= nack_d;
    end
  end

  // Checks
  `I2CEBM_ASSERT(a_err_only_with_done, !res.ack_error || res.done_res)
  `I2CEBM_ASSERT_NEXT(a_done_returns_idle, accept_i && res.done_res, state_q == ST_IDLE)
  `I2CEBM_ASSERT(a_bit_count_bounded, bit_q <= 4'd8)
  `I2CEBM_ASSERT_NEXT(a_start_leaves_idle, accept_i && start && !res.done_res,
                      state_q != ST_IDLE)

endmodule

// File: hdl/i2cebm_out_reg.sv
// Result register between the sequencer and the output channel
module i2cebm_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  i2cebm_pkg::res_t  res_i,
  output logic              ready_o,
  i2cebm_out_if.source      out_o
);
  import i2cebm_pkg::*;

  logic valid_q;
  res_t data_q;

  // Room for a new result when empty or when the held one leaves now
  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.scl_level    = data_q.scl_level;
  assign out_o.sda_pull_low = data_q.sda_pull_low;
  assign out_o.busy_res     = data_q.busy_res;
  assign out_o.done_res     = data_q.done_res;
  assign out_o.ack_error    = data_q.ack_error;
  assign out_o.read_byte    = data_q.read_byte;

endmodule

// File: hdl/i2c_eeprom_byte_master_top.sv
// Top level of the I2C EEPROM byte master: one tick in, one bus result out
// A tick's result is registered and is valid in the cycle after the tick is accepted.
// Throughput: one tick per cycle while out_o.ready holds; the result register frees as it is taken.
// The sequencer state and line levels advance once per accepted tick.
// Reset (rst_ni low, asynchronous): bus idle, registers at device 80, one tick per phase.
// No clearing pass; ticks are accepted from the first cycle after reset.
module i2c_eeprom_byte_master_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cebm_in_if.sink     in_i,
  i2cebm_cfg_if.sink    cfg_i,
  i2cebm_out_if.source  out_o
);
  import i2cebm_pkg::*;

  logic  accept;
  logic  ready;
  item_t item;
  res_t  res;

  // Input transaction completes when the result register has room
  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  assign item.kind       = in_i.kind;
  assign item.mem_addr   = in_i.mem_addr;
  assign item.write_data = in_i.write_data;
  assign item.sda_in     = in_i.sda_in;

  i2cebm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg_i),
    .res_o    (res)
  );

  i2cebm_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res),
    .ready_o (ready),
    .out_o   (out_o)
  );

endmodule
